/* sv/sdf_pkg.sv */
package sdf_pkg;

    localparam logic [6:0]  MAX_OCTETS = 7'd127;
    localparam logic [6:0]  COUNT_SAT  = 7'd127;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam int          QDEPTH     = 4;
    localparam int          QPTR_W     = $clog2(QDEPTH);
    localparam int          QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [1:0] ST_GOOD     = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_BADLEN   = 2'd2;

    localparam logic KIND_OCTET  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [3:0] symbol;
        logic       frame_end;
    } t_sdf_in_req;

    typedef struct packed {
        logic       kind;
        logic [7:0] octet;
        logic [1:0] frame_status;
        logic [6:0] frame_length;
        logic       last_of_run;
    } t_sdf_out_req;

    typedef struct packed {
        logic [1:0]   num;
        t_sdf_out_req first;
        t_sdf_out_req second;
    } t_sdf_push;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* sv/sdf_core.sv */
module sdf_core #(
    parameter logic [6:0] MAX_FRAME_OCTETS = sdf_pkg::MAX_OCTETS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  sdf_pkg::t_sdf_in_req i_req,
    output sdf_pkg::t_sdf_push   o_push
);
    import sdf_pkg::*;

    logic        r_phase, n_phase;
    logic [3:0]  r_low, n_low;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [1:0]  r_held_cnt, n_held_cnt;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_too_long, n_too_long;

    logic [7:0]   oct;
    logic [15:0]  fcs;
    logic [1:0]   status;
    t_sdf_out_req res_oct;
    t_sdf_out_req res_st;

    always_comb begin
        n_phase    = r_phase;
        n_low      = r_low;
        n_crc      = r_crc;
        n_held0    = r_held0;
        n_held1    = r_held1;
        n_held_cnt = r_held_cnt;
        n_cnt      = r_cnt;
        n_too_long = r_too_long | (r_cnt >= MAX_FRAME_OCTETS);
        oct        = {i_req.symbol, r_low};

        if (!r_phase) begin
            n_low   = i_req.symbol;
            n_phase = 1'b1;
        end else begin
            n_phase = 1'b0;
            if (r_held_cnt == 2'd2) begin
                n_crc   = crc_feed(r_crc, reverse8(r_held0));
                n_held0 = r_held1;
                n_held1 = oct;
            end else begin
                if (r_held_cnt[0]) begin
                    n_held1 = oct;
                end else begin
                    n_held0 = oct;
                end
                n_held_cnt = r_held_cnt + 2'd1;
            end
            if (r_cnt < COUNT_SAT) begin
                n_cnt = r_cnt + 7'd1;
            end
        end

        fcs = {reverse8(n_held0), reverse8(n_held1)};
        if (n_phase || n_cnt < 7'd2 || n_too_long) begin
            status = ST_BADLEN;
        end else if (fcs == n_crc) begin
            status = ST_GOOD;
        end else begin
            status = ST_MISMATCH;
        end

        res_oct              = '0;
        res_oct.kind         = KIND_OCTET;
        res_oct.octet        = oct;
        res_oct.last_of_run  = ~i_req.frame_end;
        res_st               = '0;
        res_st.kind          = KIND_STATUS;
        res_st.frame_status  = status;
        res_st.frame_length  = n_cnt;
        res_st.last_of_run   = 1'b1;

        o_push = '0;
        if (i_take) begin
            if (r_phase && i_req.frame_end) begin
                o_push.num    = 2'd2;
                o_push.first  = res_oct;
                o_push.second = res_st;
            end else if (r_phase) begin
                o_push.num   = 2'd1;
                o_push.first = res_oct;
            end else if (i_req.frame_end) begin
                o_push.num   = 2'd1;
                o_push.first = res_st;
            end
        end

        if (i_req.frame_end) begin
            n_phase    = 1'b0;
            n_low      = '0;
            n_crc      = '0;
            n_held0    = '0;
            n_held1    = '0;
            n_held_cnt = '0;
            n_cnt      = '0;
            n_too_long = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 1'b0;
            r_low      <= '0;
            r_crc      <= '0;
            r_held0    <= '0;
            r_held1    <= '0;
            r_held_cnt <= '0;
            r_cnt      <= '0;
            r_too_long <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_low      <= n_low;
            r_crc      <= n_crc;
            r_held0    <= n_held0;
            r_held1    <= n_held1;
            r_held_cnt <= n_held_cnt;
            r_cnt      <= n_cnt;
            r_too_long <= n_too_long;
        end
    end

endmodule

/* sv/sdf_outq.sv */
module sdf_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sdf_pkg::t_sdf_push    i_push,
    output logic                  o_no_room,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sdf_pkg::t_sdf_out_req o_out_req
);
    import sdf_pkg::*;

    t_sdf_out_req      r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              pop;
    logic [QPTR_W-1:0] wr_next;

    assign pop         = (r_count != '0) && !i_out_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_req   = r_mem[r_rd];
    assign o_no_room   = (r_count > QCNT_W'(QDEPTH - 2));
    assign wr_next     = r_wr + QPTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QPTR_W'(i_push.num);
            r_rd    <= r_rd + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push.num) - QCNT_W'(pop);
        end
    end

endmodule

/* sv/symbol_deframer_fcs_check.sv */
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_stall | i_in_req  (symbol, frame_end)
// out     | output    | o_out_valid/ i_out_stall | o_out_req (kind, octet, status, length, last)
//
// One symbol is accepted per cycle while o_in_stall is low; its state update (octet pairing,
// one-octet CRC step, FCS compare) completes in that cycle and its 0 to 2 results are
// registered into a 4-entry result queue that presents them at the output in order.
// o_in_stall rises while the queue has room for fewer than two results.
// i_rst_n is synchronous, active low, and empties the queue and clears frame state.
module symbol_deframer_fcs_check #(
    parameter logic [6:0] MAX_FRAME_OCTETS = sdf_pkg::MAX_OCTETS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  sdf_pkg::t_sdf_in_req  i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output sdf_pkg::t_sdf_out_req o_out_req
);
    import sdf_pkg::*;

    logic      take;
    t_sdf_push push;

    assign take = i_in_valid && !o_in_stall;

    sdf_core #(
        .MAX_FRAME_OCTETS (MAX_FRAME_OCTETS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_req   (i_in_req),
        .o_push  (push)
    );

    sdf_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_no_room   (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

endmodule

/* sv/sdf_checker.sv */
module sdf_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input sdf_pkg::t_sdf_out_req o_out_req
);
    import sdf_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_req))
        else $error("stalled result changed");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.kind == KIND_STATUS |-> o_out_req.last_of_run
            && o_out_req.octet == 8'd0)
        else $error("status report not last of run");

    a_good_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.kind == KIND_STATUS && o_out_req.frame_status == ST_GOOD
            |-> o_out_req.frame_length >= 7'd2)
        else $error("good frame shorter than check sequence");

    a_octet_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.kind == KIND_OCTET
            |-> o_out_req.frame_status == ST_GOOD && o_out_req.frame_length == 7'd0)
        else $error("octet result carries status fields");

endmodule

bind symbol_deframer_fcs_check sdf_checker u_sdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_req   (o_out_req)
);

/* tb/sv/tb_symbol_deframer_fcs_check.sv */
module tb_symbol_deframer_fcs_check;
    timeunit 1ns;
    timeprecision 1ps;

    import sdf_pkg::*;

    localparam int PREDICTED    = -1;
    localparam int ITEM_TARGET  = 1650;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_START   = 300;
    localparam int HOLD_LEN     = 60;
    localparam int CALM_START   = 900;
    localparam int CALM_END     = 1300;
    localparam int IDLE_PCT     = 16;

    typedef struct {
        t_sdf_in_req  req;
        int           fixed_n;
        t_sdf_out_req r0;
        t_sdf_out_req r1;
    } t_stim_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_stall;
    t_sdf_in_req  i_in_req;
    logic         o_out_valid;
    logic         i_out_stall;
    t_sdf_out_req o_out_req;

    int cycle_cnt = 0;
    int errors = 0;
    int items_sent = 0;

    t_sdf_out_req pending_results[$];
    t_sdf_out_req step_results[$];
    t_stim_row    stim_rows[$];
    logic [7:0]   frame_octets[$];

    logic        rx_phase;
    logic [3:0]  rx_low;
    logic [15:0] rx_crc;
    logic [7:0]  rx_held[2];
    int          rx_held_cnt;
    logic [6:0]  rx_count;
    logic        rx_too_long;

    symbol_deframer_fcs_check dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic bit calm();
        return cycle_cnt >= CALM_START && cycle_cnt < CALM_END;
    endfunction

    function automatic logic [7:0] mirror_byte(input logic [7:0] v);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    endfunction

    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ d[k];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void clear_frame();
        rx_phase    = 1'b0;
        rx_low      = '0;
        rx_crc      = '0;
        rx_held[0]  = '0;
        rx_held[1]  = '0;
        rx_held_cnt = 0;
        rx_count    = '0;
        rx_too_long = 1'b0;
    endfunction

    function automatic void deframe_step(input t_sdf_in_req req);
        t_sdf_out_req r;
        logic [7:0]   oct;
        logic [15:0]  fcs;
        step_results.delete();
        if (rx_count >= MAX_OCTETS) rx_too_long = 1'b1;
        if (!rx_phase) begin
            rx_low   = req.symbol;
            rx_phase = 1'b1;
        end else begin
            oct      = {req.symbol, rx_low};
            rx_phase = 1'b0;
            r        = '0;
            r.kind   = KIND_OCTET;
            r.octet  = oct;
            step_results.insert(step_results.size(), r);
            if (rx_held_cnt >= 2) begin
                rx_crc     = crc16_next(rx_crc, mirror_byte(rx_held[0]));
                rx_held[0] = rx_held[1];
                rx_held[1] = oct;
            end else begin
                rx_held[rx_held_cnt] = oct;
                rx_held_cnt++;
            end
            if (rx_count < COUNT_SAT) rx_count++;
        end
        if (req.frame_end) begin
            r      = '0;
            r.kind = KIND_STATUS;
            if (rx_phase || rx_count < 2 || rx_too_long) begin
                r.frame_status = ST_BADLEN;
            end else begin
                fcs = {mirror_byte(rx_held[0]), mirror_byte(rx_held[1])};
                r.frame_status = (fcs == rx_crc) ? ST_GOOD : ST_MISMATCH;
            end
            r.frame_length = rx_count;
            step_results.insert(step_results.size(), r);
            clear_frame();
        end
        if (step_results.size() > 0) begin
            step_results[step_results.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    function automatic t_sdf_out_req octet_res(input logic [7:0] oct, input logic last);
        t_sdf_out_req r;
        r             = '0;
        r.kind        = KIND_OCTET;
        r.octet       = oct;
        r.last_of_run = last;
        return r;
    endfunction

    function automatic t_sdf_out_req status_res(input logic [1:0] st, input logic [6:0] len);
        t_sdf_out_req r;
        r              = '0;
        r.kind         = KIND_STATUS;
        r.frame_status = st;
        r.frame_length = len;
        r.last_of_run  = 1'b1;
        return r;
    endfunction

    task automatic add_row(input logic [3:0] sym, input logic fe, input int fixed_n = PREDICTED,
                           input t_sdf_out_req r0 = '0, input t_sdf_out_req r1 = '0);
        t_stim_row row;
        row.req.symbol    = sym;
        row.req.frame_end = fe;
        row.fixed_n       = fixed_n;
        row.r0            = r0;
        row.r1            = r1;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    task automatic send_symbol(input t_sdf_in_req req, input int fixed_n = PREDICTED,
                               input t_sdf_out_req r0 = '0, input t_sdf_out_req r1 = '0);
        if (!calm() && $urandom_range(99) < IDLE_PCT) begin
            repeat ($urandom_range(1, 2)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        deframe_step(req);
        items_sent++;
        if (fixed_n == PREDICTED) begin
            foreach (step_results[k]) begin
                pending_results.insert(pending_results.size(), step_results[k]);
            end
        end else begin
            if (fixed_n > 0) pending_results.insert(pending_results.size(), r0);
            if (fixed_n > 1) pending_results.insert(pending_results.size(), r1);
        end
    endtask

    task automatic send_frame(input int n_data, input bit corrupt);
        logic [15:0] c;
        logic [7:0]  d;
        int          pos;
        t_sdf_in_req req;
        frame_octets.delete();
        c = '0;
        repeat (n_data) begin
            d = 8'($urandom);
            frame_octets.insert(frame_octets.size(), d);
            c = crc16_next(c, mirror_byte(d));
        end
        frame_octets.insert(frame_octets.size(), mirror_byte(c[15:8]));
        frame_octets.insert(frame_octets.size(), mirror_byte(c[7:0]));
        if (corrupt) begin
            pos = $urandom_range(frame_octets.size() - 1);
            frame_octets[pos] = frame_octets[pos] ^ (8'h01 << $urandom_range(7));
        end
        for (int k = 0; k < frame_octets.size(); k++) begin
            req.symbol    = frame_octets[k][3:0];
            req.frame_end = 1'b0;
            send_symbol(req);
            req.symbol    = frame_octets[k][7:4];
            req.frame_end = (k == frame_octets.size() - 1);
            send_symbol(req);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_sdf_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: expected nothing, got %p", $time, o_out_req);
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(o_out_req.kind));
                check_field("octet", want.octet, o_out_req.octet);
                check_field("frame_status", 8'(want.frame_status),
                            8'(o_out_req.frame_status));
                check_field("frame_length", 8'(want.frame_length),
                            8'(o_out_req.frame_length));
                check_field("last_of_run", 8'(want.last_of_run),
                            8'(o_out_req.last_of_run));
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        repeat (HOLD_START) begin
            @(negedge i_clk);
            i_out_stall <= !calm() && $urandom_range(99) < IDLE_PCT;
        end
        repeat (HOLD_LEN) begin
            @(negedge i_clk);
            i_out_stall <= 1'b1;
        end
        forever begin
            @(negedge i_clk);
            i_out_stall <= !calm() && $urandom_range(99) < IDLE_PCT;
        end
    end

    initial begin
        t_sdf_in_req req;
        int          n;
        int          pick;
        int          frame_idx;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_req   = '0;
        clear_frame();

        add_row(4'hF, 1'b1, 1, status_res(ST_BADLEN, 7'd0));
        add_row(4'h0, 1'b0, 0);
        add_row(4'hF, 1'b1, 2, octet_res(8'hF0, 1'b0), status_res(ST_BADLEN, 7'd1));
        add_row(4'h0, 1'b0, 0);
        add_row(4'h0, 1'b0, 1, octet_res(8'h00, 1'b1));
        add_row(4'h0, 1'b0, 0);
        add_row(4'h0, 1'b1, 2, octet_res(8'h00, 1'b0), status_res(ST_GOOD, 7'd2));
        for (int k = 0; k < 6; k++) add_row(4'hF, k == 5);
        add_row(4'h0, 1'b0);
        add_row(4'h8, 1'b0);
        add_row(4'h8, 1'b0);
        add_row(4'h0, 1'b0);
        add_row(4'h4, 1'b0);
        add_row(4'h8, 1'b1);
        add_row(4'h1, 1'b0);
        add_row(4'h2, 1'b0);
        add_row(4'h3, 1'b1);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            send_symbol(stim_rows[k].req, stim_rows[k].fixed_n, stim_rows[k].r0,
                        stim_rows[k].r1);
        end

        frame_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (frame_idx == 0) begin
                send_frame(125, 1'b0);
            end else if (frame_idx == 1) begin
                send_frame(126, 1'b0);
            end else if (frame_idx == 2) begin
                send_frame(130, 1'b0);
            end else if (pick < 85) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
                send_frame(n, pick >= 70);
            end else begin
                n = $urandom_range(1, 7);
                for (int k = 0; k < n; k++) begin
                    req.symbol    = 4'($urandom);
                    req.frame_end = (k == n - 1);
                    send_symbol(req);
                end
            end
            frame_idx++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/sdf_pkg.sv
sv/sdf_core.sv
sv/sdf_outq.sv
sv/symbol_deframer_fcs_check.sv
sv/sdf_checker.sv
tb/sv/tb_symbol_deframer_fcs_check.sv
